// ----- sv/scpw_pkg.sv -----
// Shared constants for the sigma-clip pixel weight block.
`timescale 1ns / 1ps
`default_nettype none
package scpw_pkg;

    localparam int VALUE_WIDTH_DEFAULT  = 32;
    localparam int WEIGHT_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int SKY_W   = 31;
    localparam int CS_W    = 16;
    localparam int LIMB_W  = 32;
    localparam int CFG_IDX_W = 3;

    // exact comparison scaling: 2^24 on the deviation, 2^32 on the variance
    localparam int DEV_SHIFT = 24;
    localparam int VAR_SHIFT = 32;

    // one in Q8.8 (threshold factor where the mask is set)
    localparam logic [CS_W-1:0] UNIT_Q8 = 16'd256;

    // reset values
    localparam longint SAT_RESET = 1792000;
    localparam logic [SKY_W-1:0] SKY_RESET = 31'd1280;
    localparam logic [CS_W-1:0] CLIP_SIGMA_RESET = 16'd1280;
    localparam logic [CS_W-1:0] SOURCE_FACTOR_RESET = 16'd2560;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_SAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_SAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_SKY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_SKY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_SIGMA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FAC = 3'd5;

endpackage
`default_nettype wire

// ----- sv/scpw_mul.sv -----
// Three-stage unsigned multiplier built from 32x32 limb products.
`timescale 1ns / 1ps
`default_nettype none
module scpw_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    import scpw_pkg::*;

    localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
    localparam int PW = AW + BW;

    logic [NA*LIMB_W-1:0] a_ext;
    logic [NB*LIMB_W-1:0] b_ext;
    logic [2*LIMB_W-1:0]  pp_reg  [NA][NB];
    logic [PW-1:0]        row_reg [NA];
    logic [PW-1:0]        row_next [NA];
    logic [PW-1:0]        p_next;
    logic [PW-1:0]        p_reg;

    assign a_ext = (NA*LIMB_W)'(a);
    assign b_ext = (NB*LIMB_W)'(b);

    // limb products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= a_ext[i*LIMB_W +: LIMB_W] * b_ext[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    // sum each row of limb products
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (LIMB_W*j));
            end
        end
    end

    // sum the rows
    always_comb begin
        p_next = '0;
        for (int i = 0; i < NA; i++) begin
            p_next = p_next + (row_reg[i] << (LIMB_W*i));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= row_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ----- sv/sigma_clip_pixel_weight_top.sv -----
// Top level of the sigma-clip pixel weight pipeline.
// Throughput: one item per cycle; the 14-stage pipeline advances whenever
// the output register is empty or being taken, so s_ready only drops while
// a result is held. Reset clears all valid bits and loads the configuration
// registers with their defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module sigma_clip_pixel_weight_top #(
    parameter int VALUE_WIDTH  = scpw_pkg::VALUE_WIDTH_DEFAULT,
    parameter int WEIGHT_WIDTH = scpw_pkg::WEIGHT_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [scpw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] cfg_data,
    // input items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [VALUE_WIDTH-1:0]          s_data_value,
    input  logic [WEIGHT_WIDTH-1:0]                s_data_weight,
    input  logic                                   s_mask_is_zero,
    input  logic signed [VALUE_WIDTH-1:0]          s_stack_value,
    input  logic [WEIGHT_WIDTH-1:0]                s_stack_weight,
    // result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [VALUE_WIDTH-1:0]          m_new_data_value,
    output logic [WEIGHT_WIDTH-1:0]                m_new_weight,
    output logic                                   m_was_clipped,
    output logic                                   m_was_invalid
);
    import scpw_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int WW = WEIGHT_WIDTH;
    localparam int NST = 14;              // stages before the output register

    localparam int AD_W   = VW + 1;       // |a - s|
    localparam int PV_W   = VW - 1;       // positive part of a value
    localparam int AD2_W  = 2 * AD_W;
    localparam int S2_W   = 2 * PV_W;
    localparam int WWS_W  = 2 * WW;
    localparam int KKS_W  = 2 * SKY_W;
    localparam int AKS_W  = PV_W + SKY_W;
    localparam int CSF_W  = 2 * CS_W;
    localparam int TN_W   = 3 * CS_W;
    localparam int P_W    = WWS_W + KKS_W;
    localparam int XA_W   = WW + KKS_W;
    localparam int XC_W   = AKS_W + WW;
    localparam int XS_W   = ((XA_W > XC_W) ? XA_W : XC_W) + 2;
    localparam int TS2_W  = TN_W + S2_W;
    localparam int TX_W   = TN_W + XS_W;
    localparam int DM_W   = AD2_W + DEV_SHIFT;
    localparam int DF_W   = TS2_W + 1;
    localparam int L_W    = P_W + DM_W;
    localparam int R_W    = TX_W + VAR_SHIFT;
    localparam int C_W    = (L_W > R_W) ? L_W : R_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [VW-1:0]  data_sat_reg, stack_sat_reg;
    logic [SKY_W-1:0]      data_sky_reg, stack_sky_reg;
    logic [CS_W-1:0]       clip_sigma_reg, source_factor_reg;
    logic [SKY_W-1:0]      k_eff, ks_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_sat_reg      <= VW'(SAT_RESET);
            stack_sat_reg     <= VW'(SAT_RESET);
            data_sky_reg      <= SKY_RESET;
            stack_sky_reg     <= SKY_RESET;
            clip_sigma_reg    <= CLIP_SIGMA_RESET;
            source_factor_reg <= SOURCE_FACTOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DATA_SAT:   data_sat_reg      <= cfg_data[VW-1:0];
                REG_STACK_SAT:  stack_sat_reg     <= cfg_data[VW-1:0];
                REG_DATA_SKY:   data_sky_reg      <= cfg_data[SKY_W-1:0];
                REG_STACK_SKY:  stack_sky_reg     <= cfg_data[SKY_W-1:0];
                REG_CLIP_SIGMA: clip_sigma_reg    <= cfg_data[CS_W-1:0];
                REG_SOURCE_FAC: source_factor_reg <= cfg_data[CS_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // a zero sky level acts as the smallest positive level
    assign k_eff  = (data_sky_reg  == '0) ? SKY_W'(1) : data_sky_reg;
    assign ks_eff = (stack_sky_reg == '0) ? SKY_W'(1) : stack_sky_reg;

    // ---------------------------------------------------------------
    // Pipeline control: every stage advances together
    // ---------------------------------------------------------------
    logic adv;
    logic vld_reg [NST];
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) vld_reg[i] <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NST; i++) vld_reg[i] <= vld_reg[i-1];
            m_valid_reg <= vld_reg[NST-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: validity, deviation magnitude, positive parts
    // ---------------------------------------------------------------
    logic signed [AD_W-1:0] diff;
    logic [AD_W-1:0]  ad_next;
    logic [PV_W-1:0]  ap_next, sp_next;
    logic             inv_next;

    assign diff = AD_W'(s_data_value) - AD_W'(s_stack_value);
    assign ad_next = diff[AD_W-1] ? (AD_W'(0) - diff) : diff;
    assign ap_next = (!s_data_value[VW-1] && (|s_data_value))
                   ? s_data_value[PV_W-1:0] : '0;
    assign sp_next = (!s_stack_value[VW-1] && (|s_stack_value))
                   ? s_stack_value[PV_W-1:0] : '0;
    assign inv_next = !((|s_data_weight) && (|s_stack_weight)
                        && (s_stack_value < stack_sat_reg)
                        && (s_data_value < data_sat_reg));

    logic [AD_W-1:0]        ad0_reg;
    logic [PV_W-1:0]        ap0_reg, sp0_reg;
    logic [CS_W-1:0]        f0_reg;
    logic [WW-1:0]          ws_pipe_reg [4];
    logic signed [VW-1:0]   a_pipe_reg [NST];
    logic [WW-1:0]          w_pipe_reg [NST];
    logic                   inv_pipe_reg [NST];

    always_ff @(posedge aclk) begin
        if (adv) begin
            ad0_reg <= ad_next;
            ap0_reg <= ap_next;
            sp0_reg <= sp_next;
            f0_reg  <= s_mask_is_zero ? source_factor_reg : UNIT_Q8;
            ws_pipe_reg[0]  <= s_stack_weight;
            a_pipe_reg[0]   <= s_data_value;
            w_pipe_reg[0]   <= s_data_weight;
            inv_pipe_reg[0] <= inv_next;
            for (int i = 1; i < 4; i++) ws_pipe_reg[i] <= ws_pipe_reg[i-1];
            for (int i = 1; i < NST; i++) begin
                a_pipe_reg[i]   <= a_pipe_reg[i-1];
                w_pipe_reg[i]   <= w_pipe_reg[i-1];
                inv_pipe_reg[i] <= inv_pipe_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 1-3: first products
    // ---------------------------------------------------------------
    logic [WWS_W-1:0] wws3;
    logic [KKS_W-1:0] kks3;
    logic [AD2_W-1:0] ad2_3;
    logic [S2_W-1:0]  s2_3;
    logic [AKS_W-1:0] aks3, sk3;
    logic [CSF_W-1:0] csf3;

    scpw_mul #(.AW(WW),   .BW(WW))    u_wws (.aclk, .en(adv), .a(w_pipe_reg[0]),
                                             .b(ws_pipe_reg[0]), .p(wws3));
    scpw_mul #(.AW(SKY_W), .BW(SKY_W)) u_kks (.aclk, .en(adv), .a(k_eff), .b(ks_eff),
                                             .p(kks3));
    scpw_mul #(.AW(AD_W), .BW(AD_W))  u_ad2 (.aclk, .en(adv), .a(ad0_reg), .b(ad0_reg),
                                             .p(ad2_3));
    scpw_mul #(.AW(PV_W), .BW(PV_W))  u_s2  (.aclk, .en(adv), .a(sp0_reg), .b(sp0_reg),
                                             .p(s2_3));
    scpw_mul #(.AW(PV_W), .BW(SKY_W)) u_aks (.aclk, .en(adv), .a(ap0_reg), .b(ks_eff),
                                             .p(aks3));
    scpw_mul #(.AW(PV_W), .BW(SKY_W)) u_sk  (.aclk, .en(adv), .a(sp0_reg), .b(k_eff),
                                             .p(sk3));
    scpw_mul #(.AW(CS_W), .BW(CS_W))  u_csf (.aclk, .en(adv), .a(f0_reg),
                                             .b(clip_sigma_reg), .p(csf3));

    // ---------------------------------------------------------------
    // Stages 4-6: P = w*ws*k*ks, variance terms, threshold
    // ---------------------------------------------------------------
    logic [P_W-1:0]   p6;
    logic [XA_W-1:0]  xa6, xb6;
    logic [XC_W-1:0]  xc6, xd6;
    logic [TN_W-1:0]  tn6;

    scpw_mul #(.AW(WWS_W), .BW(KKS_W)) u_p  (.aclk, .en(adv), .a(wws3), .b(kks3), .p(p6));
    scpw_mul #(.AW(WW), .BW(KKS_W))    u_xa (.aclk, .en(adv), .a(ws_pipe_reg[3]),
                                            .b(kks3), .p(xa6));
    scpw_mul #(.AW(WW), .BW(KKS_W))    u_xb (.aclk, .en(adv), .a(w_pipe_reg[3]),
                                            .b(kks3), .p(xb6));
    scpw_mul #(.AW(AKS_W), .BW(WW))    u_xc (.aclk, .en(adv), .a(aks3),
                                            .b(ws_pipe_reg[3]), .p(xc6));
    scpw_mul #(.AW(AKS_W), .BW(WW))    u_xd (.aclk, .en(adv), .a(sk3),
                                            .b(w_pipe_reg[3]), .p(xd6));
    scpw_mul #(.AW(CSF_W), .BW(CS_W))  u_tn (.aclk, .en(adv), .a(csf3),
                                            .b(clip_sigma_reg), .p(tn6));

    // hold s^2 until the threshold arrives, ad^2 until the threshold product
    logic [S2_W-1:0]  s2_d_reg  [3];
    logic [AD2_W-1:0] ad2_d_reg [6];
    logic [XS_W-1:0]  xs7_reg;
    logic [TN_W-1:0]  tn7_reg;
    logic [P_W-1:0]   p_d_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_d_reg[0]  <= s2_3;
            ad2_d_reg[0] <= ad2_3;
            for (int i = 1; i < 3; i++) s2_d_reg[i] <= s2_d_reg[i-1];
            for (int i = 1; i < 6; i++) ad2_d_reg[i] <= ad2_d_reg[i-1];
            // stage 7: sum the variance terms over the common denominator
            xs7_reg <= XS_W'(xa6) + XS_W'(xb6) + XS_W'(xc6) + XS_W'(xd6);
            tn7_reg <= tn6;
            p_d_reg[0] <= p6;
            for (int i = 1; i < 4; i++) p_d_reg[i] <= p_d_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Stages 7-10: threshold times s^2 and times the variance sum
    // ---------------------------------------------------------------
    logic [TS2_W-1:0] ts2_9;
    logic [TX_W-1:0]  tx10;

    scpw_mul #(.AW(TN_W), .BW(S2_W)) u_ts2 (.aclk, .en(adv), .a(tn6), .b(s2_d_reg[2]),
                                           .p(ts2_9));
    scpw_mul #(.AW(TN_W), .BW(XS_W)) u_tx  (.aclk, .en(adv), .a(tn7_reg), .b(xs7_reg),
                                           .p(tx10));

    // stage 10: D = ad^2 * 2^24 - T * s^2; only a positive D can clip
    logic [DF_W-1:0] dfull;
    logic [DM_W-1:0] dm10_reg;
    logic            pos_d_reg [4];
    logic [TX_W-1:0] tx_d_reg [3];

    assign dfull = DF_W'({ad2_d_reg[5], {DEV_SHIFT{1'b0}}}) - DF_W'(ts2_9);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dm10_reg    <= dfull[DM_W-1:0];
            pos_d_reg[0] <= !dfull[DF_W-1] && (|dfull);
            for (int i = 1; i < 4; i++) pos_d_reg[i] <= pos_d_reg[i-1];
            tx_d_reg[0] <= tx10;
            for (int i = 1; i < 3; i++) tx_d_reg[i] <= tx_d_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Stages 11-13: P * D, then compare against T * X * 2^32
    // ---------------------------------------------------------------
    logic [L_W-1:0] l13;
    logic           clip;

    scpw_mul #(.AW(P_W), .BW(DM_W)) u_l (.aclk, .en(adv), .a(p_d_reg[3]), .b(dm10_reg),
                                        .p(l13));

    assign clip = !inv_pipe_reg[NST-1] && pos_d_reg[3]
                  && (C_W'(l13) > C_W'({tx_d_reg[2], {VAR_SHIFT{1'b0}}}));

    // stage 14: output register
    logic signed [VW-1:0] out_a_reg;
    logic [WW-1:0]        out_w_reg;
    logic                 out_clip_reg, out_inv_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_a_reg    <= clip ? '0 : a_pipe_reg[NST-1];
            out_w_reg    <= (clip || inv_pipe_reg[NST-1]) ? '0 : w_pipe_reg[NST-1];
            out_clip_reg <= clip;
            out_inv_reg  <= inv_pipe_reg[NST-1];
        end
    end

    assign m_new_data_value = out_a_reg;
    assign m_new_weight     = out_w_reg;
    assign m_was_clipped    = out_clip_reg;
    assign m_was_invalid    = out_inv_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_was_clipped && m_was_invalid))
        else $error("clipped and invalid both set");

    a_clip_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_was_clipped) |-> (m_new_data_value == '0 && m_new_weight == '0))
        else $error("clipped item not zeroed");

    a_invalid_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_was_invalid) |-> (m_new_weight == '0))
        else $error("invalid item kept its weight");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid)) |-> $past(vld_reg[NST-1]))
        else $error("result appeared without a pipeline item");

endmodule
`default_nettype wire

// ----- test/scpw_checker.sv -----
// Result checker for the sigma-clip pixel weight block: predicts and compares every item.
`timescale 1ns / 1ps
module scpw_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [scpw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [31:0]            s_data_value,
    input  logic [31:0]                   s_data_weight,
    input  logic                          s_mask_is_zero,
    input  logic signed [31:0]            s_stack_value,
    input  logic [31:0]                   s_stack_weight,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [31:0]            m_new_data_value,
    input  logic [31:0]                   m_new_weight,
    input  logic                          m_was_clipped,
    input  logic                          m_was_invalid,
    output int                            fail_count,
    output int                            pending,
    output int                            checked_count,
    output int                            clipped_count,
    output int                            invalid_count
);
    import scpw_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        weight;
        logic               clipped;
        logic               invalid;
    } pixel_out_t;

    logic signed [31:0] data_sat, stack_sat;
    logic [SKY_W-1:0]   data_sky, stack_sky;
    logic [CS_W-1:0]    clip_sigma, source_fac;
    pixel_out_t         expected_q[$];

    function automatic pixel_out_t clip_pixel(logic signed [31:0] a, logic [31:0] w,
                                              logic mask0, logic signed [31:0] s,
                                              logic [31:0] ws);
        pixel_out_t r;
        logic [255:0] k, ks, p, v, lhs, rhs, ad, tnum;
        longint diff;
        k  = (data_sky == 0) ? 256'd1 : 256'(data_sky);
        ks = (stack_sky == 0) ? 256'd1 : 256'(stack_sky);
        r.value = a;
        r.weight = w;
        r.clipped = 1'b0;
        r.invalid = 1'b0;
        if (w != 0 && ws != 0 && s < stack_sat && a < data_sat) begin
            diff = longint'(a) - longint'(s);
            ad = (diff < 0) ? 256'(-diff) : 256'(diff);
            tnum = 256'(clip_sigma) * 256'(clip_sigma)
                 * (mask0 ? 256'(source_fac) : 256'(UNIT_Q8));
            p = 256'(w) * 256'(ws) * k * ks;
            // variance scaled by the common denominator and 2^32
            v = (256'(ws) * k * ks + 256'(w) * k * ks) << VAR_SHIFT;
            if (a > 0)
                v = v + ((256'(unsigned'(a)) * 256'(ws) * ks) << VAR_SHIFT);
            if (s > 0) begin
                v = v + 256'(unsigned'(s)) * 256'(unsigned'(s)) * p;
                v = v + ((256'(unsigned'(s)) * 256'(w) * k) << VAR_SHIFT);
            end
            lhs = ((ad * ad) << DEV_SHIFT) * p;
            rhs = tnum * v;
            if (lhs > rhs) begin
                r.value = '0;
                r.weight = '0;
                r.clipped = 1'b1;
            end
        end else begin
            r.weight = '0;
            r.invalid = 1'b1;
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        pixel_out_t e;
        if (!aresetn) begin
            data_sat <= 32'(SAT_RESET);
            stack_sat <= 32'(SAT_RESET);
            data_sky <= SKY_RESET;
            stack_sky <= SKY_RESET;
            clip_sigma <= CLIP_SIGMA_RESET;
            source_fac <= SOURCE_FACTOR_RESET;
            expected_q.delete();
            fail_count <= 0;
            checked_count <= 0;
            clipped_count <= 0;
            invalid_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DATA_SAT:   data_sat <= cfg_data;
                    REG_STACK_SAT:  stack_sat <= cfg_data;
                    REG_DATA_SKY:   data_sky <= cfg_data[SKY_W-1:0];
                    REG_STACK_SKY:  stack_sky <= cfg_data[SKY_W-1:0];
                    REG_CLIP_SIGMA: clip_sigma <= cfg_data[CS_W-1:0];
                    REG_SOURCE_FAC: source_fac <= cfg_data[CS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.push_back(clip_pixel(s_data_value, s_data_weight, s_mask_is_zero,
                                                s_stack_value, s_stack_weight));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    checked_count <= checked_count + 1;
                    clipped_count <= clipped_count + e.clipped;
                    invalid_count <= invalid_count + e.invalid;
                    if (m_new_data_value !== e.value ||
                        m_new_weight !== e.weight ||
                        m_was_clipped !== e.clipped ||
                        m_was_invalid !== e.invalid)
                        fail_count <= fail_count + 1;
                    if (m_new_data_value !== e.value)
                        $error("new_data_value: expected %0d, got %0d",
                               e.value, m_new_data_value);
                    if (m_new_weight !== e.weight)
                        $error("new_weight: expected %0h, got %0h", e.weight, m_new_weight);
                    if (m_was_clipped !== e.clipped)
                        $error("was_clipped: expected %0b, got %0b", e.clipped, m_was_clipped);
                    if (m_was_invalid !== e.invalid)
                        $error("was_invalid: expected %0b, got %0b", e.invalid, m_was_invalid);
                end
            end
        end
    end
endmodule

// ----- test/sigma_clip_pixel_weight_top_tb.sv -----
// Testbench top for the sigma-clip pixel weight block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module sigma_clip_pixel_weight_top_tb;
    import scpw_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 190;
    localparam int PHASES      = 8;
    localparam int DRAIN_WAIT  = 30;  // comfortably longer than the pipeline

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [31:0]   s_data_value = '0;
    logic [31:0]          s_data_weight = '0;
    logic                 s_mask_is_zero = 1'b0;
    logic signed [31:0]   s_stack_value = '0;
    logic [31:0]          s_stack_weight = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [31:0]   m_new_data_value;
    logic [31:0]          m_new_weight;
    logic                 m_was_clipped;
    logic                 m_was_invalid;

    int fail_count, pending, checked_count, clipped_count, invalid_count;
    int cycle_count = 0;

    always #10 aclk = ~aclk;

    sigma_clip_pixel_weight_top u_top (.*);

    scpw_checker u_checker (.*);

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, with a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Throttle the result side: ready runs and stalls of random length.
    initial begin
        int hold;
        bit rdy;
        hold = 0;
        rdy = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                rdy = ($urandom_range(0, 2) != 0);
                hold = rdy ? $urandom_range(1, 40) : idle_len() + 1;
            end
            m_ready <= rdy;
            hold--;
        end
    end

    // Present one item after a random gap and hold it until accepted.
    task automatic send_pixel(logic signed [31:0] a, logic [31:0] w, logic mask0,
                              logic signed [31:0] s, logic [31:0] ws);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_value <= a;
        s_data_weight <= w;
        s_mask_is_zero <= mask0;
        s_stack_value <= s;
        s_stack_weight <= ws;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off input until every outstanding item has come back, then let the pipe drain.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 2000 * 256)) - 200 * 256;
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hffffffff - $urandom_range(0, 3);
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    // Mostly a stack value near the image value, so clipping goes both ways.
    task automatic send_random_pixel();
        logic signed [31:0] s, a, off;
        int scale;
        s = rand_value();
        if ($urandom_range(0, 4) == 0) begin
            a = rand_value();
        end else begin
            scale = $urandom_range(0, 24);
            off = $urandom_range(0, 1 << scale);
            a = $urandom_range(0, 1) ? s + off : s - off;
        end
        send_pixel(a, rand_weight(), 1'($urandom), s, rand_weight());
    endtask

    function automatic logic [31:0] rand_sat();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h7fffffff;
            default: return $urandom_range(100 * 256, 8000 * 256);
        endcase
    endfunction

    function automatic logic [31:0] rand_sky();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return $urandom & 32'h7fffffff;
            default: return $urandom_range(1, 64 * 256);
        endcase
    endfunction

    function automatic logic [31:0] rand_q8();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return $urandom & 32'hffff;
            default: return $urandom_range(256, 16 * 256);
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset configuration.
        send_pixel(32'sd0, 32'd0, 1'b0, 32'sd0, 32'd65536);          // zero image weight
        send_pixel(32'sd0, 32'd65536, 1'b0, 32'sd0, 32'd0);          // zero stack weight
        send_pixel(32'sd1792000, 32'd65536, 1'b0, 32'sd0, 32'd65536); // image at saturation
        send_pixel(32'sd0, 32'd65536, 1'b1, 32'sd1792000, 32'd65536); // stack at saturation
        send_pixel(32'sd1791999, 32'd65536, 1'b0, 32'sd1791999, 32'd65536);
        send_pixel(32'sh80000000, 32'd65536, 1'b0, 32'sh80000000, 32'd65536);
        send_pixel(32'sh7fffffff, 32'hffffffff, 1'b1, 32'sh80000000, 32'hffffffff);
        send_pixel(32'sh80000000, 32'hffffffff, 1'b0, 32'sd1000000, 32'hffffffff);
        send_pixel(32'sh80000000, 32'hffffffff, 1'b1, 32'sd1000000, 32'hffffffff);
        send_pixel(32'sd25600, 32'd65536, 1'b0, 32'sd25600, 32'd65536); // kept, no deviation
        send_pixel(32'sd25600, 32'd65536, 1'b0, 32'sd0, 32'd65536);
        send_pixel(32'sd25600, 32'd65536, 1'b1, 32'sd0, 32'd65536);
        send_pixel(-32'sd25600, 32'd1, 1'b0, -32'sd256000, 32'd1);
        send_pixel(-32'sd256000, 32'hffffffff, 1'b0, 32'sd256000, 32'hffffffff);
        send_pixel(-32'sd256000, 32'hffffffff, 1'b1, 32'sd256000, 32'hffffffff);
        drain_pipe();

        // Zero threshold and zero sky levels.
        write_reg(REG_CLIP_SIGMA, 32'd0);
        write_reg(REG_DATA_SKY, 32'd0);
        write_reg(REG_STACK_SKY, 32'd0);
        send_pixel(32'sd256, 32'd65536, 1'b0, 32'sd256, 32'd65536);
        send_pixel(32'sd257, 32'd65536, 1'b0, 32'sd256, 32'd65536);
        send_pixel(32'sd257, 32'd65536, 1'b1, 32'sd256, 32'd65536);
        send_pixel(32'sd5000, 32'd7, 1'b0, 32'sd4000, 32'd3);
        drain_pipe();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    // loosest limits
                    write_reg(REG_DATA_SAT, 32'h7fffffff);
                    write_reg(REG_STACK_SAT, 32'h7fffffff);
                    write_reg(REG_DATA_SKY, 32'h7fffffff);
                    write_reg(REG_STACK_SKY, 32'h7fffffff);
                    write_reg(REG_CLIP_SIGMA, 32'hffff);
                    write_reg(REG_SOURCE_FAC, 32'hffff);
                end
                1: begin
                    // everything saturates
                    write_reg(REG_DATA_SAT, 32'h80000000);
                    write_reg(REG_STACK_SAT, 32'h80000000);
                    write_reg(REG_DATA_SKY, 32'd1);
                    write_reg(REG_STACK_SKY, 32'd1);
                    write_reg(REG_CLIP_SIGMA, 32'd256);
                    write_reg(REG_SOURCE_FAC, 32'd0);
                end
                default: begin
                    write_reg(REG_DATA_SAT, rand_sat());
                    write_reg(REG_STACK_SAT, rand_sat());
                    write_reg(REG_DATA_SKY, rand_sky());
                    write_reg(REG_STACK_SKY, rand_sky());
                    write_reg(REG_CLIP_SIGMA, rand_q8());
                    write_reg(REG_SOURCE_FAC, rand_q8());
                end
            endcase
            repeat (PHASE_ITEMS) send_random_pixel();
            drain_pipe();
        end

        $display("Checked %0d pixels over %0d register settings: %0d clipped, %0d invalid.",
                 checked_count, PHASES + 2, clipped_count, invalid_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
